FILE: src/soas_pkg.sv
package soas_pkg;

  localparam int unsigned MODE_W  = 3;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned FOUND_W = 6;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned DATA_W  = 32;

  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_TRANS  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MTF    = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;
  localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

  localparam logic [LEN_W-1:0] CAPACITY_RESET = 7'd64;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [FOUND_W-1:0] found_index;
    logic [LEN_W-1:0]   new_length;
  } res_t;

endpackage

FILE: src/soas_cfg.sv
module soas_cfg (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [soas_pkg::LEN_W-1:0] capacity_o
);

  logic [soas_pkg::LEN_W-1:0] capacity_q, capacity_d;
  logic                       wr_en;

  // Only the upper address bit selects a register; byte offsets are ignored.
  assign wr_en = psel && penable && pwrite && (paddr[2] == 1'b0);

  always_comb begin
    capacity_d = capacity_q;
    if (wr_en) begin
      capacity_d = pwdata[soas_pkg::LEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= soas_pkg::CAPACITY_RESET;
    end else begin
      capacity_q <= capacity_d;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr[2] == 1'b0) ? {{(32-soas_pkg::LEN_W){1'b0}}, capacity_q} : 32'd0;
  assign capacity_o = capacity_q;

endmodule

FILE: src/soas_engine.sv
module soas_engine #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          ready_o,
  input  logic [soas_pkg::MODE_W-1:0]   mode_i,
  input  logic [soas_pkg::LEN_W-1:0]    position_i,
  input  logic [soas_pkg::DATA_W-1:0]   operand_value_i,
  input  logic [soas_pkg::LEN_W-1:0]    capacity_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output soas_pkg::res_t                res_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [soas_pkg::LEN_W-1:0] DEPTH_CAP =
    (DEPTH > 127) ? 7'd127 : soas_pkg::LEN_W'(DEPTH);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_SRCH = 3'd3;
  localparam logic [2:0] S_SWA  = 3'd4;
  localparam logic [2:0] S_SWB  = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;

  logic [soas_pkg::DATA_W-1:0] mem [DEPTH];
  logic [soas_pkg::DATA_W-1:0] rdata_q;

  logic [2:0]                   state_q, state_d;
  logic [soas_pkg::LEN_W-1:0]   cnt_q, cnt_d;
  logic [soas_pkg::LEN_W-1:0]   ptr_q, ptr_d;
  logic [soas_pkg::LEN_W-1:0]   wa_q, wa_d;
  logic                         pend_q, pend_d;
  logic [soas_pkg::MODE_W-1:0]  mode_q, mode_d;
  logic [soas_pkg::LEN_W-1:0]   pos_q, pos_d;
  logic [soas_pkg::DATA_W-1:0]  key_q, key_d;
  logic [soas_pkg::DATA_W-1:0]  prev_q, prev_d;
  logic [soas_pkg::DATA_W-1:0]  e0_q, e0_d;
  logic [soas_pkg::LEN_W-1:0]   hit_q, hit_d;
  logic [soas_pkg::ST_W-1:0]    status_q, status_d;
  logic [soas_pkg::FOUND_W-1:0] found_q, found_d;

  logic [soas_pkg::LEN_W-1:0]   limit;
  logic                         we, re;
  logic [soas_pkg::LEN_W-1:0]   waddr, raddr;
  logic [soas_pkg::DATA_W-1:0]  wdata;

  assign limit = (capacity_i > DEPTH_CAP) ? DEPTH_CAP : capacity_i;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ptr_d    = ptr_q;
    wa_d     = wa_q;
    pend_d   = 1'b0;
    mode_d   = mode_q;
    pos_d    = pos_q;
    key_d    = key_q;
    prev_d   = prev_q;
    e0_d     = e0_q;
    hit_d    = hit_q;
    status_d = status_q;
    found_d  = found_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = key_q;
    re       = 1'b0;
    raddr    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          mode_d   = mode_i;
          pos_d    = position_i;
          key_d    = operand_value_i;
          status_d = soas_pkg::ST_OK;
          found_d  = '0;
          state_d  = S_FIN;
          case (mode_i) inside
            soas_pkg::MODE_APPEND: begin
              if (cnt_q < limit) begin
                we    = 1'b1;
                waddr = cnt_q;
                wdata = operand_value_i;
                cnt_d = cnt_q + 7'd1;
              end else begin
                status_d = soas_pkg::ST_FULL;
              end
            end
            soas_pkg::MODE_INSERT: begin
              if (cnt_q >= limit) begin
                status_d = soas_pkg::ST_FULL;
              end else if (position_i > cnt_q) begin
                status_d = soas_pkg::ST_RANGE;
              end else begin
                ptr_d   = cnt_q;
                state_d = S_INS;
              end
            end
            soas_pkg::MODE_DELETE: begin
              if (position_i >= cnt_q) begin
                status_d = soas_pkg::ST_RANGE;
              end else begin
                ptr_d   = position_i;
                state_d = S_DEL;
              end
            end
            soas_pkg::MODE_SEARCH, soas_pkg::MODE_TRANS, soas_pkg::MODE_MTF: begin
              ptr_d   = '0;
              state_d = S_SRCH;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk down from the end: read slot ptr-1, write it one slot up once the read data is registered.
      S_INS: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata_q;
        end
        if (ptr_q > pos_q) begin
          re     = 1'b1;
          raddr  = ptr_q - 7'd1;
          wa_d   = ptr_q;
          ptr_d  = ptr_q - 7'd1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          we      = 1'b1;
          waddr   = pos_q;
          wdata   = key_q;
          cnt_d   = cnt_q + 7'd1;
          state_d = S_FIN;
        end
      end

      // Walk up from the hole: read slot ptr+1, write it one slot down.
      S_DEL: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = wa_q;
          wdata = rdata_q;
        end
        if (ptr_q + 7'd1 < cnt_q) begin
          re     = 1'b1;
          raddr  = ptr_q + 7'd1;
          wa_d   = ptr_q;
          ptr_d  = ptr_q + 7'd1;
          pend_d = 1'b1;
        end else if (!pend_q) begin
          cnt_d   = cnt_q - 7'd1;
          state_d = S_FIN;
        end
      end

      // Reads stream one slot per cycle; the compare works on the registered read data.
      // The last non-matching word and slot 0 are kept for the swaps.
      S_SRCH: begin
        if (pend_q && (rdata_q == key_q)) begin
          hit_d   = wa_q;
          found_d = wa_q[soas_pkg::FOUND_W-1:0];
          if (((mode_q == soas_pkg::MODE_TRANS) || (mode_q == soas_pkg::MODE_MTF)) &&
              (wa_q != '0)) begin
            state_d = S_SWA;
          end else begin
            state_d = S_FIN;
          end
        end else begin
          if (pend_q) begin
            prev_d = rdata_q;
            if (wa_q == '0) begin
              e0_d = rdata_q;
            end
          end
          if (ptr_q < cnt_q) begin
            re     = 1'b1;
            raddr  = ptr_q;
            wa_d   = ptr_q;
            ptr_d  = ptr_q + 7'd1;
            pend_d = 1'b1;
          end else if (!pend_q) begin
            status_d = soas_pkg::ST_MISS;
            state_d  = S_FIN;
          end
        end
      end

      // The hit equals the key, so the partner slot receives the key.
      S_SWA: begin
        we      = 1'b1;
        waddr   = (mode_q == soas_pkg::MODE_TRANS) ? (hit_q - 7'd1) : '0;
        wdata   = key_q;
        state_d = S_SWB;
      end

      S_SWB: begin
        we      = 1'b1;
        waddr   = hit_q;
        wdata   = (mode_q == soas_pkg::MODE_TRANS) ? prev_q : e0_q;
        state_d = S_FIN;
      end

      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[AW'(waddr)] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[AW'(raddr)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    wa_q     <= wa_d;
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    prev_q   <= prev_d;
    e0_q     <= e0_d;
    hit_q    <= hit_d;
    status_q <= status_d;
    found_q  <= found_d;
  end

  assign ready_o           = (state_q == S_IDLE);
  assign res_valid_o       = (state_q == S_FIN);
  assign res_o.status      = status_q;
  assign res_o.found_index = found_q;
  assign res_o.new_length  = cnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DEPTH_CAP)
    else $error("element count exceeds the array limit");

  a_pend_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ($past(state_q) == S_INS || $past(state_q) == S_DEL ||
                $past(state_q) == S_SRCH))
    else $error("read data pending outside a walk");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && ready_o) |=> !ready_o)
    else $error("engine idle right after taking an item");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 7'd1 ||
    cnt_q == $past(cnt_q) - 7'd1)
    else $error("element count moved by more than one");

endmodule

FILE: src/self_organizing_array_store_core.sv
// Self-organizing array store: holds up to min(capacity, DEPTH) signed 32-bit
// elements in one single-ported-read, single-ported-write memory and serves
// append, insert, delete, plain search, transposition search and move-to-head
// search, one item at a time, each answered with status, found index and new
// length. Insert and delete move every element between the position and the
// end, each with one memory read and a write of the registered read data; a
// search reads the elements in order up to the hit or the end, and a hit away
// from the head under transposition or move-to-head adds two writes for the
// swap. The memory hands out one element per cycle. A finished result waits in
// an output register, so the next item is taken while it is still unread. The
// memory needs no clearing after reset.
module self_organizing_array_store_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // mode [2:0], position [9:3], operand_value [41:10]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // status [1:0], found_index [7:2], new_length [14:8]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [soas_pkg::LEN_W-1:0] capacity;
  logic                       res_valid, res_ready;
  soas_pkg::res_t             res;
  logic                       out_valid_q, out_valid_d;
  soas_pkg::res_t             out_q, out_d;

  soas_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .capacity_o (capacity)
  );

  soas_engine #(
    .DEPTH (DEPTH)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .mode_i          (s_axis_tdata[2:0]),
    .position_i      (s_axis_tdata[9:3]),
    .operand_value_i (s_axis_tdata[41:10]),
    .capacity_i      (capacity),
    .res_valid_o     (res_valid),
    .res_ready_i     (res_ready),
    .res_o           (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.new_length, out_q.found_index, out_q.status};

endmodule

FILE: tb/sv/testbench.sv
module testbench;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_DEPTH = 64;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 150;
  localparam logic [2:0] REG_CAPACITY = 3'd0;
  localparam logic [soas_pkg::MODE_W-1:0] MODE_UNDEF_LO = 3'd6;
  localparam logic [soas_pkg::MODE_W-1:0] MODE_UNDEF_HI = 3'd7;

  // Same layout as s_axis_tdata below the padding: mode in the lowest bits.
  typedef struct packed {
    logic [soas_pkg::DATA_W-1:0] operand;
    logic [soas_pkg::LEN_W-1:0]  position;
    logic [soas_pkg::MODE_W-1:0] mode;
  } request_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;   // mode [2:0], position [9:3], operand_value [41:10]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // status [1:0], found_index [7:2], new_length [14:8]
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  self_organizing_array_store_core #(
    .DEPTH(STORE_DEPTH)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the store: contents, length and capacity register.
  logic [soas_pkg::DATA_W-1:0] slots [int];
  int unsigned                 held = 0;
  logic [soas_pkg::LEN_W-1:0]  cap_reg = soas_pkg::CAPACITY_RESET;

  request_t                    pending_q [$];
  soas_pkg::res_t              expected_q [$];
  logic [soas_pkg::DATA_W-1:0] key_pool [16];
  int unsigned                 mismatches = 0;

  function automatic soas_pkg::res_t apply_request(request_t rq);
    soas_pkg::res_t              r;
    int unsigned                 lim;
    int                          hit;
    int                          i;
    logic [soas_pkg::DATA_W-1:0] t;
    r.status = soas_pkg::ST_OK;
    r.found_index = '0;
    hit = -1;
    lim = (cap_reg > STORE_DEPTH) ? STORE_DEPTH : cap_reg;
    case (rq.mode) inside
      soas_pkg::MODE_APPEND: begin
        if (held < lim) begin
          slots[held] = rq.operand;
          held++;
        end else begin
          r.status = soas_pkg::ST_FULL;
        end
      end
      soas_pkg::MODE_INSERT: begin
        // The full check wins over a bad position.
        if (held >= lim) begin
          r.status = soas_pkg::ST_FULL;
        end else if (rq.position > held) begin
          r.status = soas_pkg::ST_RANGE;
        end else begin
          for (i = held; i > rq.position; i--) slots[i] = slots[i-1];
          slots[rq.position] = rq.operand;
          held++;
        end
      end
      soas_pkg::MODE_DELETE: begin
        if (rq.position >= held) begin
          r.status = soas_pkg::ST_RANGE;
        end else begin
          for (i = rq.position; i + 1 < held; i++) slots[i] = slots[i+1];
          held--;
        end
      end
      soas_pkg::MODE_SEARCH, soas_pkg::MODE_TRANS, soas_pkg::MODE_MTF: begin
        for (i = 0; i < held; i++) if (hit < 0 && slots[i] == rq.operand) hit = i;
        if (hit < 0) begin
          r.status = soas_pkg::ST_MISS;
        end else begin
          r.found_index = hit[soas_pkg::FOUND_W-1:0];
          if (rq.mode == soas_pkg::MODE_TRANS && hit > 0) begin
            t = slots[hit];
            slots[hit] = slots[hit-1];
            slots[hit-1] = t;
          end else if (rq.mode == soas_pkg::MODE_MTF) begin
            t = slots[hit];
            slots[hit] = slots[0];
            slots[0] = t;
          end
        end
      end
      default: ;
    endcase
    r.new_length = held[soas_pkg::LEN_W-1:0];
    return r;
  endfunction

  function automatic request_t make_request(logic [soas_pkg::MODE_W-1:0] m,
                                            logic [soas_pkg::LEN_W-1:0] p,
                                            logic [soas_pkg::DATA_W-1:0] v);
    request_t rq;
    rq.mode = m;
    rq.position = p;
    rq.operand = v;
    return rq;
  endfunction

  // Keys mostly come from a small pool so that searches hit and duplicates occur.
  // A growing phase favors append and insert, a shrinking one favors delete.
  function automatic request_t random_request(bit grow);
    request_t rq;
    int       pick;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 19) == 0) key_pool[4'($urandom_range(0, 15))] = $urandom;
    rq.operand = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[4'($urandom_range(0, 15))];
    if ($urandom_range(0, 9) == 0) begin
      rq.position = soas_pkg::LEN_W'($urandom_range(0, 127));
    end else begin
      rq.position = soas_pkg::LEN_W'($urandom_range(0, $urandom_range(0, 64)));
    end
    if (pick < (grow ? 25 : 12)) rq.mode = soas_pkg::MODE_APPEND;
    else if (pick < (grow ? 45 : 22)) rq.mode = soas_pkg::MODE_INSERT;
    else if (pick < 55) rq.mode = soas_pkg::MODE_DELETE;
    else if (pick < 68) rq.mode = soas_pkg::MODE_SEARCH;
    else if (pick < 81) rq.mode = soas_pkg::MODE_TRANS;
    else if (pick < 95) rq.mode = soas_pkg::MODE_MTF;
    else rq.mode = $urandom_range(0, 1) ? MODE_UNDEF_LO : MODE_UNDEF_HI;
    return rq;
  endfunction

  // Sender: bursts of random length separated by random gaps, some of them empty.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  request_t    in_flight;

  always @(posedge clk_i) begin : feed
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) expected_q.push_back(apply_request(in_flight));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          in_flight = pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {6'b0, in_flight};
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: segments of always-ready, coin-flip and mostly-stalled behavior, plus
  // one long hold-off that lets the block back up into its input.
  int unsigned results_taken = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned seg_left = 0;
  int unsigned seg_kind = 0;

  always @(posedge clk_i) begin : drain
    logic rdy;
    rdy = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
      end else if (results_taken == 400 && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end else begin
        if (seg_left == 0) begin
          seg_left = $urandom_range(10, 150);
          seg_kind = $urandom_range(0, 2);
        end
        seg_left--;
        case (seg_kind)
          0: rdy = 1'b1;
          1: rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
    m_axis_tready <= rdy;
  end

  always @(posedge clk_i) begin : check
    soas_pkg::res_t want;
    soas_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.found_index = m_axis_tdata[7:2];
      got.new_length = m_axis_tdata[14:8];
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          mismatches++;
        end
        if (got.found_index !== want.found_index) begin
          $error("found_index: expected %0d, got %0d", want.found_index, got.found_index);
          mismatches++;
        end
        if (got.new_length !== want.new_length) begin
          $error("new_length: expected %0d, got %0d", want.new_length, got.new_length);
          mismatches++;
        end
      end
    end
  end

  int unsigned stuck = 0;

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable)) begin
      stuck <= 0;
    end else if (stuck == STALL_LIMIT) begin
      $display("[self_organizing_array_store_core] ERROR");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [soas_pkg::LEN_W-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_CAPACITY;
    pwdata <= {25'b0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = value;
  endtask

  task automatic run_phase(input logic [soas_pkg::LEN_W-1:0] cap, input int unsigned n,
                           input bit grow);
    write_capacity(cap);
    repeat (n) pending_q.push_back(random_request(grow));
    wait_drained();
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'h0000_0001;
    key_pool[2] = 32'hFFFF_FFFF;
    key_pool[3] = 32'h7FFF_FFFF;
    key_pool[4] = 32'h8000_0000;
    for (int k = 5; k < 16; k++) key_pool[4'(k)] = $urandom;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty store: delete out of range and misses for every search kind, then three appends and an insert at the head.
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd0, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_SEARCH, 7'd0, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_TRANS, 7'd0, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_MTF, 7'd0, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_APPEND, 7'd127, 32'h8000_0000));
    pending_q.push_back(make_request(soas_pkg::MODE_APPEND, 7'd0, 32'h7FFF_FFFF));
    pending_q.push_back(make_request(soas_pkg::MODE_APPEND, 7'd64, 32'hFFFF_FFFF));
    pending_q.push_back(make_request(soas_pkg::MODE_INSERT, 7'd0, 32'd5));
    // Insert at the length appends; past it is out of range.
    pending_q.push_back(make_request(soas_pkg::MODE_INSERT, 7'd4, 32'd6));
    pending_q.push_back(make_request(soas_pkg::MODE_INSERT, 7'd127, 32'd7));
    pending_q.push_back(make_request(soas_pkg::MODE_INSERT, 7'd6, 32'd7));
    // Transposition hit at the head swaps nothing.
    pending_q.push_back(make_request(soas_pkg::MODE_TRANS, 7'd0, 32'd5));
    pending_q.push_back(make_request(soas_pkg::MODE_TRANS, 7'd0, 32'hFFFF_FFFF));
    pending_q.push_back(make_request(soas_pkg::MODE_MTF, 7'd0, 32'd6));
    pending_q.push_back(make_request(soas_pkg::MODE_SEARCH, 7'd0, 32'h7FFF_FFFF));
    pending_q.push_back(make_request(soas_pkg::MODE_SEARCH, 7'd0, 32'd12345));
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd5, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd127, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd4, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd0, 32'd0));
    pending_q.push_back(make_request(MODE_UNDEF_LO, 7'd127, 32'hA5A5_5A5A));
    pending_q.push_back(make_request(MODE_UNDEF_HI, 7'd0, 32'h5A5A_A5A5));
    wait_drained();

    // Capacity below the current length: the elements stay, growth is refused.
    write_capacity(7'd2);
    pending_q.push_back(make_request(soas_pkg::MODE_APPEND, 7'd0, 32'd9));
    pending_q.push_back(make_request(soas_pkg::MODE_INSERT, 7'd127, 32'd9));
    pending_q.push_back(make_request(soas_pkg::MODE_DELETE, 7'd1, 32'd0));
    pending_q.push_back(make_request(soas_pkg::MODE_MTF, 7'd0, 32'h8000_0000));
    wait_drained();

    run_phase(7'd64, 140, 1'b1);
    run_phase(7'd5, 140, 1'b0);
    run_phase(7'd0, 140, 1'b0);
    run_phase(7'd127, 250, 1'b1);
    run_phase(7'd1, 140, 1'b0);
    run_phase(7'd100, 140, 1'b1);
    run_phase(7'd33, 140, 1'b0);
    run_phase(7'd64, 140, 1'b1);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("[self_organizing_array_store_core] OK");
    end else begin
      $display("[self_organizing_array_store_core] ERROR");
    end
    $finish;
  end

endmodule
